[design/cbpf_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier path follower package
// Beat types, configuration register codes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpf_pkg;

    // Fixed field widths.
    localparam int COORD_W    = 32;
    localparam int DELTA_W    = 16;
    localparam int SLOT_W     = 4;
    localparam int RATE_W     = 16;
    localparam int PCOUNT_W   = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int NUM_AXES   = 3;

    // Reset values of the configuration registers.
    localparam logic [RATE_W-1:0]   STEP_RATE_RST   = 16'd6554;
    localparam logic [PCOUNT_W-1:0] POINT_COUNT_RST = 5'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b1;

    // Item kinds.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Q0.30 constants.
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;

    // Last control point of a segment.
    localparam logic [1:0] LAST_K = 2'd3;

    typedef struct packed {
        logic                      mode;
        logic [SLOT_W-1:0]         point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [DELTA_W-1:0]        time_delta;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      finished;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_PARAM,
        ST_SQ,
        ST_WSQ,
        ST_CUBE,
        ST_T3,
        ST_W3,
        ST_MAC,
        ST_ACC,
        ST_RND,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_INC,
        MUL_SQ,
        MUL_CUBE,
        MUL_T3,
        MUL_BLEND
    } mul_op_t;

    typedef struct packed {
        logic       load_wr;
        logic       tick_start;
        mul_op_t    mul_op;
        logic       param_upd;
        logic       wsq_cap;
        logic       wcube_cap;
        logic       w3_cap;
        logic       rd_en;
        logic [1:0] rd_k;
        logic [1:0] mac_k;
        logic       acc_clr;
        logic       acc_add;
        logic       pos_upd;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic live;
    } stat_t;

endpackage

`default_nettype wire

[design/cbpf_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array and read data register.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/cbpf_ctrl.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier path follower controller
// Sequences the shared multiplier lanes through one tick and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_mode,
    output logic             out_valid,
    input  logic             out_ready,
    output cbpf_pkg::cmd_t   cmd,
    input  cbpf_pkg::stat_t  stat
);

    cbpf_pkg::state_t state_reg, state_next;
    logic [1:0]       k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign in_ready  = (state_reg == cbpf_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // State, point counter and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbpf_pkg::ST_IDLE;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        unique case (state_reg)
            cbpf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == cbpf_pkg::MODE_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = stat.live ? cbpf_pkg::ST_INC : cbpf_pkg::ST_OUT;
                    end
                end
            end
            cbpf_pkg::ST_INC:
            begin
                cmd.mul_op = cbpf_pkg::MUL_INC;
                state_next = cbpf_pkg::ST_PARAM;
            end
            cbpf_pkg::ST_PARAM:
            begin
                cmd.param_upd = 1'b1;
                state_next    = cbpf_pkg::ST_SQ;
            end
            cbpf_pkg::ST_SQ:
            begin
                cmd.mul_op = cbpf_pkg::MUL_SQ;
                state_next = cbpf_pkg::ST_WSQ;
            end
            cbpf_pkg::ST_WSQ:
            begin
                cmd.wsq_cap = 1'b1;
                state_next  = cbpf_pkg::ST_CUBE;
            end
            cbpf_pkg::ST_CUBE:
            begin
                cmd.mul_op = cbpf_pkg::MUL_CUBE;
                state_next = cbpf_pkg::ST_T3;
            end
            cbpf_pkg::ST_T3:
            begin
                cmd.mul_op    = cbpf_pkg::MUL_T3;
                cmd.wcube_cap = 1'b1;
                state_next    = cbpf_pkg::ST_W3;
            end
            cbpf_pkg::ST_W3:
            begin
                // First control point is fetched while the last weight settles.
                cmd.w3_cap  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_k    = 2'd0;
                cmd.acc_clr = 1'b1;
                k_next      = 2'd0;
                state_next  = cbpf_pkg::ST_MAC;
            end
            cbpf_pkg::ST_MAC:
            begin
                cmd.mul_op  = cbpf_pkg::MUL_BLEND;
                cmd.mac_k   = k_reg;
                cmd.acc_add = (k_reg != 2'd0);
                if (k_reg != cbpf_pkg::LAST_K)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.rd_k  = k_reg + 2'd1;
                    k_next    = k_reg + 2'd1;
                end
                else
                begin
                    state_next = cbpf_pkg::ST_ACC;
                end
            end
            cbpf_pkg::ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = cbpf_pkg::ST_RND;
            end
            cbpf_pkg::ST_RND:
            begin
                cmd.pos_upd = 1'b1;
                state_next  = cbpf_pkg::ST_OUT;
            end
            cbpf_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cbpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbpf_pkg::ST_IDLE;
            end
        endcase
    end

    // The output register holds a beat until the consumer takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

`default_nettype wire

[design/cbpf_dpath.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier path follower datapath
// Control point table, curve parameter, Bernstein weights, three multiplier
// lanes with accumulators, position and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpf_dpath #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cbpf_pkg::in_beat_t                   in_data,
    input  cbpf_pkg::cmd_t                       cmd,
    output cbpf_pkg::stat_t                      stat,
    input  logic                                 cfg_we,
    input  logic [cbpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbpf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output cbpf_pkg::out_beat_t                  out_data
);

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int SEG_W   = $clog2(MAX_POINTS / 4 + 1);
    localparam int CNT_W   = ($clog2(MAX_POINTS + 1) > cbpf_pkg::PCOUNT_W) ?
                             $clog2(MAX_POINTS + 1) : cbpf_pkg::PCOUNT_W;
    localparam int PAR_W   = FRAC_BITS + 1;
    localparam int T_SHIFT = 30 - FRAC_BITS;
    localparam int PT_W    = cbpf_pkg::NUM_AXES * cbpf_pkg::COORD_W;
    localparam int NA      = cbpf_pkg::NUM_AXES;

    localparam logic [PAR_W-1:0]  ONE_P   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // Rounds a Q0.60 product to Q0.30.
    function automatic logic [30:0] rnd30(input logic signed [63:0] p);
        logic [63:0] s;
        s = 64'(p) + cbpf_pkg::Q30_HALF;
        return s[60:30];
    endfunction

    // Configuration registers.
    logic [cbpf_pkg::RATE_W-1:0]   step_rate_reg, step_rate_next;
    logic [cbpf_pkg::PCOUNT_W-1:0] point_count_reg, point_count_next;

    // Path state.
    logic [PAR_W-1:0] param_reg, param_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic             done_reg, done_next;
    logic signed [cbpf_pkg::COORD_W-1:0] pos_reg [NA];
    logic signed [cbpf_pkg::COORD_W-1:0] pos_next [NA];

    // Working registers of one tick.
    logic [cbpf_pkg::DELTA_W-1:0] td_reg, td_next;
    logic             wrap_reg, wrap_next;
    logic [30:0]      t_reg, t_next, u_reg, u_next;
    logic [30:0]      u2_reg, u2_next, t2_reg, t2_next;
    logic [31:0]      w_reg [4];
    logic [31:0]      w_next [4];
    logic signed [63:0] prod_reg [NA];
    logic signed [63:0] prod_next [NA];
    logic signed [63:0] acc_reg [NA];
    logic signed [63:0] acc_next [NA];
    cbpf_pkg::out_beat_t out_reg, out_next;

    // Combinational helpers.
    logic [CNT_W-1:0]   used_pts, seg_cnt;
    logic               seg_ge;
    logic [FRAC_BITS-1:0] inc;
    logic [PAR_W:0]     np;
    logic [PAR_W-1:0]   np_sat, clip;
    logic [30:0]        t_calc, u_calc;
    logic [30:0]        r1, r2;
    logic signed [32:0] mul_a [NA];
    logic signed [32:0] mul_b [NA];
    logic signed [65:0] mul_full [NA];
    logic signed [63:0] rnd_pos [NA];
    logic [PT_W-1:0]    ram_rdata;
    logic signed [cbpf_pkg::COORD_W-1:0] rd_pt [NA];
    logic               slot_ok;

    // Control point table.
    assign slot_ok = 32'(in_data.point_index) < 32'(MAX_POINTS);

    cbpf_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load_wr && slot_ok),
        .waddr (ADDR_W'(in_data.point_index)),
        .wdata ({in_data.point_z, in_data.point_y, in_data.point_x}),
        .re    (cmd.rd_en),
        .raddr (ADDR_W'({seg_reg, cmd.rd_k})),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int c = 0; c < NA; c++)
        begin
            rd_pt[c] = $signed(ram_rdata[c*cbpf_pkg::COORD_W +: cbpf_pkg::COORD_W]);
        end
    end

    // Segment count and live check.
    assign used_pts  = (CNT_W'(point_count_reg) > CNT_W'(MAX_POINTS)) ?
                       CNT_W'(MAX_POINTS) : CNT_W'(point_count_reg);
    assign seg_cnt   = used_pts >> 2;
    assign seg_ge    = CNT_W'(seg_reg) >= seg_cnt;
    assign stat.live = !done_reg && !seg_ge;

    // Parameter step, saturation and the clipped parameter in Q0.30.
    assign inc    = prod_reg[0][31 -: FRAC_BITS];
    assign np     = {1'b0, param_reg} + (PAR_W + 1)'(inc);
    assign np_sat = np[PAR_W] ? {PAR_W{1'b1}} : np[PAR_W-1:0];
    assign clip   = np_sat[FRAC_BITS] ? ONE_P : np_sat;
    assign t_calc = 31'(clip) << T_SHIFT;
    assign u_calc = cbpf_pkg::Q30_ONE - t_calc;

    assign r1 = rnd30(prod_reg[1]);
    assign r2 = rnd30(prod_reg[2]);

    // Operand selection for the three multiplier lanes.
    always_comb
    begin
        for (int c = 0; c < NA; c++)
        begin
            mul_a[c] = '0;
            mul_b[c] = '0;
        end
        unique case (cmd.mul_op)
            cbpf_pkg::MUL_INC:
            begin
                mul_a[0] = $signed({17'd0, td_reg});
                mul_b[0] = $signed({17'd0, step_rate_reg});
            end
            cbpf_pkg::MUL_SQ:
            begin
                mul_a[0] = $signed({2'b00, u_reg});
                mul_b[0] = $signed({2'b00, u_reg});
                mul_a[1] = $signed({2'b00, t_reg});
                mul_b[1] = $signed({2'b00, t_reg});
            end
            cbpf_pkg::MUL_CUBE:
            begin
                mul_a[0] = $signed({2'b00, u2_reg});
                mul_b[0] = $signed({2'b00, u_reg});
                mul_a[1] = $signed({2'b00, u2_reg});
                mul_b[1] = $signed({2'b00, t_reg});
                mul_a[2] = $signed({2'b00, t2_reg});
                mul_b[2] = $signed({2'b00, u_reg});
            end
            cbpf_pkg::MUL_T3:
            begin
                mul_a[0] = $signed({2'b00, t2_reg});
                mul_b[0] = $signed({2'b00, t_reg});
            end
            cbpf_pkg::MUL_BLEND:
            begin
                for (int c = 0; c < NA; c++)
                begin
                    mul_a[c] = {rd_pt[c][cbpf_pkg::COORD_W-1], rd_pt[c]};
                    mul_b[c] = $signed({1'b0, w_reg[cmd.mac_k]});
                end
            end
            cbpf_pkg::MUL_NONE:
            begin
            end
            default:
            begin
            end
        endcase
        for (int c = 0; c < NA; c++)
        begin
            mul_full[c] = mul_a[c] * mul_b[c];
        end
    end

    // Rounded blend sums; saturation follows in the position update.
    always_comb
    begin
        for (int c = 0; c < NA; c++)
        begin
            rnd_pos[c] = (acc_reg[c] + $signed(cbpf_pkg::Q30_HALF)) >>> 30;
        end
    end

    // Next values of all registers.
    always_comb
    begin
        step_rate_next   = step_rate_reg;
        point_count_next = point_count_reg;
        param_next       = param_reg;
        seg_next         = seg_reg;
        done_next        = done_reg;
        td_next          = td_reg;
        wrap_next        = wrap_reg;
        t_next           = t_reg;
        u_next           = u_reg;
        u2_next          = u2_reg;
        t2_next          = t2_reg;
        out_next         = out_reg;
        for (int k = 0; k < 4; k++)
        begin
            w_next[k] = w_reg[k];
        end
        for (int c = 0; c < NA; c++)
        begin
            pos_next[c]  = pos_reg[c];
            prod_next[c] = prod_reg[c];
            acc_next[c]  = acc_reg[c];
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                cbpf_pkg::REG_STEP_RATE:
                begin
                    step_rate_next = cfg_data;
                end
                cbpf_pkg::REG_POINT_COUNT:
                begin
                    point_count_next = cfg_data[cbpf_pkg::PCOUNT_W-1:0];
                end
            endcase
        end

        // A tick with no segment left latches the finished flag for good.
        if (cmd.tick_start)
        begin
            td_next   = in_data.time_delta;
            done_next = done_reg | seg_ge;
        end

        if (cmd.param_upd)
        begin
            param_next = np_sat;
            wrap_next  = np_sat[FRAC_BITS];
            t_next     = t_calc;
            u_next     = u_calc;
        end

        if (cmd.mul_op != cbpf_pkg::MUL_NONE)
        begin
            for (int c = 0; c < NA; c++)
            begin
                prod_next[c] = $signed(mul_full[c][63:0]);
            end
        end

        if (cmd.wsq_cap)
        begin
            u2_next = rnd30(prod_reg[0]);
            t2_next = rnd30(prod_reg[1]);
        end

        // The middle weights carry the factor of three.
        if (cmd.wcube_cap)
        begin
            w_next[0] = {1'b0, rnd30(prod_reg[0])};
            w_next[1] = {1'b0, r1} + {r1, 1'b0};
            w_next[2] = {1'b0, r2} + {r2, 1'b0};
        end

        if (cmd.w3_cap)
        begin
            w_next[3] = {1'b0, rnd30(prod_reg[0])};
        end

        for (int c = 0; c < NA; c++)
        begin
            if (cmd.acc_clr)
            begin
                acc_next[c] = '0;
            end
            else if (cmd.acc_add)
            begin
                acc_next[c] = acc_reg[c] + prod_reg[c];
            end
        end

        // Position update and the wrap to the next segment.
        if (cmd.pos_upd)
        begin
            for (int c = 0; c < NA; c++)
            begin
                if (rnd_pos[c] > SAT_MAX)
                begin
                    pos_next[c] = SAT_MAX[31:0];
                end
                else if (rnd_pos[c] < SAT_MIN)
                begin
                    pos_next[c] = SAT_MIN[31:0];
                end
                else
                begin
                    pos_next[c] = rnd_pos[c][31:0];
                end
            end
            if (wrap_reg)
            begin
                param_next = '0;
                seg_next   = seg_reg + SEG_W'(1);
            end
        end

        if (cmd.out_load)
        begin
            out_next.pos_x    = pos_reg[0];
            out_next.pos_y    = pos_reg[1];
            out_next.pos_z    = pos_reg[2];
            out_next.finished = done_reg;
        end
    end

    // Registers with a reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_rate_reg   <= cbpf_pkg::STEP_RATE_RST;
            point_count_reg <= cbpf_pkg::POINT_COUNT_RST;
            param_reg       <= '0;
            seg_reg         <= '0;
            done_reg        <= 1'b0;
            for (int c = 0; c < NA; c++)
            begin
                pos_reg[c] <= '0;
            end
        end
        else
        begin
            step_rate_reg   <= step_rate_next;
            point_count_reg <= point_count_next;
            param_reg       <= param_next;
            seg_reg         <= seg_next;
            done_reg        <= done_next;
            for (int c = 0; c < NA; c++)
            begin
                pos_reg[c] <= pos_next[c];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        td_reg   <= td_next;
        wrap_reg <= wrap_next;
        t_reg    <= t_next;
        u_reg    <= u_next;
        u2_reg   <= u2_next;
        t2_reg   <= t2_next;
        out_reg  <= out_next;
        for (int k = 0; k < 4; k++)
        begin
            w_reg[k] <= w_next[k];
        end
        for (int c = 0; c < NA; c++)
        begin
            prod_reg[c] <= prod_next[c];
            acc_reg[c]  <= acc_next[c];
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[design/cubic_bezier_path_follower_core.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier path follower core
// A load beat is written to the table when it is taken. A tick beat steps
// through the parameter step, the weights, the blend of the four control
// points and rounding, and no beat is taken until its result is loaded into
// the output register. A tick past the end of the path skips the arithmetic.
// A full output register holds the sequence until the consumer takes the beat.
// Reset clears path state and position and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_path_follower_core #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cbpf_pkg::in_beat_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output cbpf_pkg::out_beat_t              out_data,
    input  logic                             cfg_we,
    input  logic [cbpf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    cbpf_pkg::cmd_t  cmd;
    cbpf_pkg::stat_t stat;

    // Sequencer.
    cbpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_mode   (in_data.mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Arithmetic and storage.
    cbpf_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
